@@ rtl/core/ppte_pkg.sv @@
package ppte_pkg;

    // table geometry
    localparam int MAX_SEGMENTS = 16;
    localparam int MAX_COEFFS   = 8;
    localparam int AXES         = 3;

    // field and datapath widths
    localparam int WORD_W      = 32;
    localparam int TIME_W      = 24;
    localparam int FRAC_W      = 16;
    localparam int SEGMENT_W   = 4;
    localparam int AXIS_W      = 2;
    localparam int INDEX_W     = 3;
    localparam int MODE_W      = 3;
    localparam int SEG_IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CIDX_W      = $clog2(MAX_COEFFS);
    localparam int CNT_W       = $clog2(MAX_COEFFS + 1);
    localparam int PROD_W      = WORD_W + TIME_W + 1;
    localparam int QUOT_W      = PROD_W - FRAC_W;
    localparam int SUM_W       = QUOT_W + 1;
    localparam int ROUND_HALF  = 1 << (FRAC_W - 1);

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration port
    localparam int            ADDR_W      = 3;
    localparam int            APB_DATA_W  = 32;
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd3;

    typedef logic [MAX_COEFFS-1:0][AXES-1:0][WORD_W-1:0] coef_row_t;

    typedef struct packed {
        logic                     operation;
        logic [SEGMENT_W-1:0]     segment;
        logic [AXIS_W-1:0]        axis;
        logic [INDEX_W-1:0]       coeff_index;
        logic signed [WORD_W-1:0] coeff_value;
        logic [TIME_W-1:0]        sample_time;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic                     overflow;
    } pos_t;

    // one evaluation in flight
    typedef struct packed {
        coef_row_t                        coef;
        logic [AXES-1:0][WORD_W-1:0]      acc;
        logic [TIME_W-1:0]                t;
        logic [CNT_W-1:0]                 count;
        logic                             ovf;
        logic                             seg_ok;
    } item_t;

endpackage

@@ rtl/core/ppte_coef_mem.sv @@
module ppte_coef_mem (
    input  logic                            clk,
    input  logic                            we,
    input  logic [ppte_pkg::SEG_IDX_W-1:0]  wseg,
    input  logic [ppte_pkg::AXIS_W-1:0]     wax,
    input  logic [ppte_pkg::CIDX_W-1:0]     wci,
    input  logic [ppte_pkg::WORD_W-1:0]     wdata,
    input  logic                            re,
    input  logic [ppte_pkg::SEG_IDX_W-1:0]  rseg,
    output ppte_pkg::coef_row_t             rdata
);
    import ppte_pkg::*;

    // one row per segment, all coefficients of all axes
    coef_row_t mem [MAX_SEGMENTS];
    coef_row_t rdata_reg;

    // single word write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wseg][wci][wax] <= wdata;
        end
    end

    // registered row read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[rseg];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ppte_horner_step.sv @@
module ppte_horner_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ppte_pkg::CIDX_W-1:0]  step_idx,
    input  logic                         in_valid,
    input  ppte_pkg::item_t              in_item,
    output logic                         in_stall,
    output logic                         out_valid,
    output ppte_pkg::item_t              out_item,
    input  logic                         out_stall
);
    import ppte_pkg::*;

    logic                     a_valid_reg;
    item_t                    a_item_reg;
    logic signed [PROD_W-1:0] a_prod_reg [AXES];
    logic                     b_valid_reg;
    item_t                    b_item_reg;
    item_t                    b_item_next;
    logic                     a_adv;
    logic                     b_adv;

    // stage advance, bubbles collapse
    assign b_adv    = !b_valid_reg || !out_stall;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_stall = !a_adv;

    // stage a: multiply accumulator by time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            a_item_reg <= in_item;
            for (int a = 0; a < AXES; a++)
            begin
                a_prod_reg[a] <= PROD_W'($signed(in_item.acc[a]))
                               * PROD_W'($signed({1'b0, in_item.t}));
            end
        end
    end

    // stage b: round, add coefficient, saturate
    always_comb
    begin
        logic                     active;
        logic [PROD_W-1:0]        rnd;
        logic [QUOT_W-1:0]        quot;
        logic [WORD_W-1:0]        cf;
        logic [SUM_W-1:0]         sum;
        logic [SUM_W-WORD_W:0]    hi;
        logic                     sat;
        b_item_next = a_item_reg;
        active      = CNT_W'(step_idx) < a_item_reg.count;
        for (int a = 0; a < AXES; a++)
        begin
            rnd  = a_prod_reg[a] + PROD_W'(ROUND_HALF);
            quot = rnd[PROD_W-1:FRAC_W];
            cf   = a_item_reg.coef[step_idx][a];
            sum  = {quot[QUOT_W-1], quot}
                 + {{(SUM_W-WORD_W){cf[WORD_W-1]}}, cf};
            hi   = sum[SUM_W-1:WORD_W-1];
            sat  = (|hi) && !(&hi);
            if (active)
            begin
                if (sat)
                begin
                    b_item_next.acc[a] = sum[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                                      : {1'b0, {(WORD_W-1){1'b1}}};
                end
                else
                begin
                    b_item_next.acc[a] = sum[WORD_W-1:0];
                end
                b_item_next.ovf = b_item_next.ovf | sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

@@ rtl/core/piecewise_poly_trajectory_eval.sv @@
// an evaluate beat passes the table read, two stages per horner step for seven steps and the output
// register before its result beat is valid
// throughput: one beat per cycle while cmd_stall is low, load or evaluate; a load gives no result
// the horner steps form a fixed chain, shorter modes pass unused steps through
// reset: pipeline emptied, mode register back to 3; coefficient table is not cleared
module piecewise_poly_trajectory_eval (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppte_pkg::ADDR_W-1:0]      paddr,
    input  logic [ppte_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppte_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  ppte_pkg::cmd_t                   cmd,
    output logic                             pos_valid,
    input  logic                             pos_stall,
    output ppte_pkg::pos_t                   pos
);
    import ppte_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              mode_sel;
    logic              accept;
    logic              load_ok;
    logic              seg_ok;
    logic [MODE_W-1:0] mode_eff;
    logic [CNT_W-1:0]  count;
    coef_row_t         row;

    logic              v0_reg;
    logic [TIME_W-1:0] t0_reg;
    logic [CNT_W-1:0]  cnt0_reg;
    logic              segok0_reg;

    logic              chain_valid [MAX_COEFFS];
    item_t             chain_item  [MAX_COEFFS];
    logic              chain_stall [MAX_COEFFS];

    logic              pos_valid_reg;
    pos_t              pos_reg;
    pos_t              pos_next;
    item_t             last;

    // configuration port
    assign pready   = 1'b1;
    assign mode_sel = paddr[ADDR_W-1:2] == '0;
    assign prdata   = mode_sel ? APB_DATA_W'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else if (psel && penable && pwrite && pready && mode_sel)
        begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    // coefficient count from mode
    always_comb
    begin
        mode_eff = (mode_reg == '0) ? MODE_W'(1) : mode_reg;
        count    = CNT_W'({mode_eff, 1'b0});
        if (count > CNT_W'(MAX_COEFFS))
        begin
            count = CNT_W'(MAX_COEFFS);
        end
    end

    // input beat and table access
    assign cmd_stall = v0_reg && chain_stall[0];
    assign accept    = cmd_valid && !cmd_stall;
    assign seg_ok    = int'(cmd.segment) < MAX_SEGMENTS;
    assign load_ok   = seg_ok && (int'(cmd.axis) < AXES)
                    && (int'(cmd.coeff_index) < MAX_COEFFS);

    ppte_coef_mem u_mem (
        .clk   (clk),
        .we    (accept && cmd.operation == OP_LOAD && load_ok),
        .wseg  (SEG_IDX_W'(cmd.segment)),
        .wax   (cmd.axis),
        .wci   (CIDX_W'(cmd.coeff_index)),
        .wdata (cmd.coeff_value),
        .re    (accept),
        .rseg  (SEG_IDX_W'(cmd.segment)),
        .rdata (row)
    );

    // stage 0 control beside the table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            v0_reg <= cmd_valid && cmd.operation == OP_EVAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t0_reg     <= cmd.sample_time;
            cnt0_reg   <= count;
            segok0_reg <= seg_ok;
        end
    end

    always_comb
    begin
        chain_item[0]        = '0;
        chain_item[0].coef   = row;
        chain_item[0].acc    = row[0];
        chain_item[0].t      = t0_reg;
        chain_item[0].count  = cnt0_reg;
        chain_item[0].ovf    = 1'b0;
        chain_item[0].seg_ok = segok0_reg;
    end
    assign chain_valid[0] = v0_reg;

    // horner steps
    for (genvar g = 1; g < MAX_COEFFS; g++)
    begin : g_step
        ppte_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_idx  (CIDX_W'(g)),
            .in_valid  (chain_valid[g-1]),
            .in_item   (chain_item[g-1]),
            .in_stall  (chain_stall[g-1]),
            .out_valid (chain_valid[g]),
            .out_item  (chain_item[g]),
            .out_stall (chain_stall[g])
        );
    end

    // output register
    assign last                        = chain_item[MAX_COEFFS-1];
    assign chain_stall[MAX_COEFFS-1]   = pos_valid_reg && pos_stall;

    always_comb
    begin
        pos_next          = '0;
        if (last.seg_ok)
        begin
            pos_next.pos_x    = last.acc[0];
            pos_next.pos_y    = last.acc[1];
            pos_next.pos_z    = last.acc[2];
            pos_next.overflow = last.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= 1'b0;
        end
        else if (!chain_stall[MAX_COEFFS-1])
        begin
            pos_valid_reg <= chain_valid[MAX_COEFFS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!chain_stall[MAX_COEFFS-1] && chain_valid[MAX_COEFFS-1])
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos_valid = pos_valid_reg;
    assign pos       = pos_reg;

    // a load beat never starts an evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.operation == OP_LOAD |=> !v0_reg)
        else $error("load beat entered the horner chain");

    // input is held back only by a full stage 0
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> v0_reg)
        else $error("input stalled with stage 0 empty");

    // coefficient count stays within the table row
    assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg |-> (cnt0_reg >= CNT_W'(2)) && (cnt0_reg <= CNT_W'(MAX_COEFFS)))
        else $error("coefficient count out of range");

    // a result waiting on the output holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_stall |=> $stable(pos_reg))
        else $error("waiting result changed");

endmodule
